@@ hdl/wsfe_pkg.sv @@
// wsfe_pkg: shared constants for the WebSocket masked frame encoder.
// No dependencies; used by the core and its checker.
package wsfe_pkg;

	// default width of the counted payload length
	localparam int LENGTH_BITS_DEFAULT = 32;

	// input command codes
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_DATA  = 1'b1;

	// length encoding thresholds and codes
	localparam logic [63:0] TINY_LIMIT  = 64'd125;
	localparam logic [63:0] SHORT_LIMIT = 64'd65535;
	localparam logic [7:0]  MASK_FLAG   = 8'h80;
	localparam logic [7:0]  SHORT_CODE  = 8'd126;
	localparam logic [7:0]  LONG_CODE   = 8'd127;

	// header layout
	localparam int KEY_BYTES   = 4;
	localparam int SHORT_EXT   = 2;
	localparam int LONG_EXT    = 8;
	localparam int MAX_BYTES   = 2 + LONG_EXT + KEY_BYTES;
	localparam int CNT_BITS    = $clog2(MAX_BYTES);

	localparam logic [CNT_BITS-1:0] LAST_TINY  = CNT_BITS'(2 + KEY_BYTES - 1);
	localparam logic [CNT_BITS-1:0] LAST_SHORT = CNT_BITS'(2 + SHORT_EXT + KEY_BYTES - 1);
	localparam logic [CNT_BITS-1:0] LAST_LONG  = CNT_BITS'(MAX_BYTES - 1);

	// key byte 0 is the most significant byte
	function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0: b = key[31:24];
			2'd1: b = key[23:16];
			2'd2: b = key[15:8];
			2'd3: b = key[7:0];
			default: b = key[31:24];
		endcase
		return b;
	endfunction

endpackage

@@ hdl/websocket_masked_frame_encoder_core.sv @@
// Client-side WebSocket frame encoder: one input register, one output register.
// Depends on wsfe_pkg for codes, limits and the key byte select.
// An item waits in the input register while the output is stalled, then its bytes pass
// one at a time through the one-byte output register: 6, 8 or 14 header bytes for a start,
// one for a payload item, none for a dropped one; a new item is taken as its last byte leaves.
// Reset (arst_n low, asynchronous): no item held, no output valid, no frame open,
// key, key index and byte count cleared.
module websocket_masked_frame_encoder_core #(
	parameter int LENGTH_BITS = wsfe_pkg::LENGTH_BITS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [7:0]  header_byte,
	input  logic [31:0] payload_length,
	input  logic [31:0] mask_key,
	input  logic [7:0]  data_byte,
	// output channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        end_of_run,
	output logic        end_of_frame
);

	// counted length: the 32-bit field cut to LENGTH_BITS
	localparam int LW = (LENGTH_BITS < 32) ? LENGTH_BITS : 32;
	localparam int CW = wsfe_pkg::CNT_BITS;
	localparam int NB = wsfe_pkg::MAX_BYTES;

	// input register: the item being emitted
	logic          valid_s1;
	logic          cmd_s1;
	logic [7:0]    header_s1;
	logic [LW-1:0] len_s1;
	logic [31:0]   key_s1;
	logic [7:0]    data_s1;
	logic [CW-1:0] cnt_q;     // next header byte position of a start

	// frame state, updated when the last byte of an item is emitted
	logic [31:0]   key_store_q;
	logic [1:0]    key_index_q;
	logic [LW-1:0] bytes_remaining_q;
	logic          frame_open_q;

	// output register
	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          end_of_run_q;
	logic          end_of_frame_q;

	logic [63:0]   len64;
	logic [7:0]    frame_bytes [NB];
	logic [CW-1:0] last_idx;
	logic          out_free;
	logic          drop;
	logic          emit;
	logic          last;
	logic          s1_done;
	logic          accept;
	logic [LW-1:0] rem_next;
	logic          data_done;
	logic [7:0]    emit_byte;
	logic          emit_eor;
	logic          emit_eof;

	assign len64 = {{(64 - LW){1'b0}}, len_s1};

	// header bytes of the held start, laid out by length class
	always_comb begin
		for (int i = 0; i < NB; i++) begin
			frame_bytes[i] = 8'h00;
		end
		frame_bytes[0] = header_s1;
		if (len64 <= wsfe_pkg::TINY_LIMIT) begin
			frame_bytes[1] = wsfe_pkg::MASK_FLAG | {1'b0, len64[6:0]};
			for (int k = 0; k < wsfe_pkg::KEY_BYTES; k++) begin
				frame_bytes[2 + k] = wsfe_pkg::key_byte(key_s1, 2'(k));
			end
			last_idx = wsfe_pkg::LAST_TINY;
		end else if (len64 <= wsfe_pkg::SHORT_LIMIT) begin
			frame_bytes[1] = wsfe_pkg::MASK_FLAG | wsfe_pkg::SHORT_CODE;
			frame_bytes[2] = len64[15:8];
			frame_bytes[3] = len64[7:0];
			for (int k = 0; k < wsfe_pkg::KEY_BYTES; k++) begin
				frame_bytes[2 + wsfe_pkg::SHORT_EXT + k] = wsfe_pkg::key_byte(key_s1, 2'(k));
			end
			last_idx = wsfe_pkg::LAST_SHORT;
		end else begin
			frame_bytes[1] = wsfe_pkg::MASK_FLAG | wsfe_pkg::LONG_CODE;
			for (int j = 0; j < wsfe_pkg::LONG_EXT; j++) begin
				frame_bytes[2 + j] = len64[63 - 8 * j -: 8];
			end
			for (int k = 0; k < wsfe_pkg::KEY_BYTES; k++) begin
				frame_bytes[2 + wsfe_pkg::LONG_EXT + k] = wsfe_pkg::key_byte(key_s1, 2'(k));
			end
			last_idx = wsfe_pkg::LAST_LONG;
		end
	end

	// payload byte bookkeeping
	assign rem_next  = bytes_remaining_q - LW'(1);
	assign data_done = (rem_next == '0);

	// handshake control
	assign out_free = !out_valid_q || out_ready;
	assign drop     = valid_s1 && (cmd_s1 == wsfe_pkg::CMD_DATA) && !frame_open_q;
	assign emit     = valid_s1 && !drop && out_free;
	assign last     = (cmd_s1 == wsfe_pkg::CMD_DATA) || (cnt_q == last_idx);
	assign s1_done  = drop || (emit && last);
	assign in_ready = !valid_s1 || s1_done;
	assign accept   = in_valid && in_ready;

	// byte that goes to the output register this cycle
	always_comb begin
		if (cmd_s1 == wsfe_pkg::CMD_DATA) begin
			emit_byte = data_s1 ^ wsfe_pkg::key_byte(key_store_q, key_index_q);
			emit_eor  = 1'b1;
			emit_eof  = data_done;
		end else begin
			emit_byte = frame_bytes[cnt_q];
			emit_eor  = (cnt_q == last_idx);
			emit_eof  = (cnt_q == last_idx) && (len_s1 == '0);
		end
	end

	// input register payload: no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1    <= command;
			header_s1 <= header_byte;
			len_s1    <= payload_length[LW-1:0];
			key_s1    <= mask_key;
			data_s1   <= data_byte;
		end
	end

	// input register control and header position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				cnt_q    <= '0;
			end else begin
				if (s1_done) begin
					valid_s1 <= 1'b0;
				end
				if (emit && !last) begin
					cnt_q <= cnt_q + CW'(1);
				end
			end
		end
	end

	// frame state: a start replaces it, a payload byte that is not dropped advances it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_store_q       <= '0;
			key_index_q       <= '0;
			bytes_remaining_q <= '0;
			frame_open_q      <= 1'b0;
		end else if (emit && last) begin
			if (cmd_s1 == wsfe_pkg::CMD_START) begin
				key_store_q       <= key_s1;
				key_index_q       <= '0;
				bytes_remaining_q <= len_s1;
				frame_open_q      <= (len_s1 != '0);
			end else begin
				key_index_q       <= key_index_q + 2'd1;
				bytes_remaining_q <= rem_next;
				frame_open_q      <= !data_done;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q     <= emit_byte;
			end_of_run_q   <= emit_eor;
			end_of_frame_q <= emit_eof;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign end_of_run   = end_of_run_q;
	assign end_of_frame = end_of_frame_q;

endmodule

@@ hdl/wsfe_checker.sv @@
// wsfe_checker: port-level assertions for the frame encoder core, plus its bind.
// Depends on wsfe_pkg and websocket_masked_frame_encoder_core.
module wsfe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       command,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       end_of_run,
	input logic       end_of_frame
);

	// stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte)
			&& $stable(end_of_run) && $stable(end_of_frame))
		else $error("stalled output beat changed");

	// frame end is always the last beat of its item
	a_eof_eor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_frame |-> end_of_run)
		else $error("end_of_frame without end_of_run");

	// header bytes of a start come without gaps
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !end_of_run |=> out_valid)
		else $error("gap inside a header run");

	// an accepted start always yields output
	a_start_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (command == wsfe_pkg::CMD_START) |-> ##2 out_valid)
		else $error("start produced no output");

endmodule

bind websocket_masked_frame_encoder_core wsfe_checker u_wsfe_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.command      (command),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.out_byte     (out_byte),
	.end_of_run   (end_of_run),
	.end_of_frame (end_of_frame)
);

@@ test/websocket_masked_frame_encoder_core_test.sv @@
// Self-checking bench for websocket_masked_frame_encoder_core: a directed table, then random frames.
// Depends on wsfe_pkg and the core; wire bytes are predicted from a local copy of the frame state.
module websocket_masked_frame_encoder_core_test;

	localparam int LEN_BITS = wsfe_pkg::LENGTH_BITS_DEFAULT;
	localparam int ROWS     = 24;

	// one beat on the wire side
	typedef struct packed {
		logic [7:0] value;
		logic       run_end;
		logic       frame_end;
	} wire_beat_t;

	// one directed row; when typed is set, the beat count and the last beat are checked
	// against the values typed in here
	typedef struct packed {
		logic        cmd;
		logic [7:0]  hdr;
		logic [31:0] len;
		logic [31:0] key;
		logic [7:0]  data;
		logic        typed;
		logic [4:0]  n_beats;
		logic [7:0]  last_value;
		logic        last_eof;
	} stim_row_t;

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        in_valid       = 1'b0;
	logic        in_ready;
	logic        command        = wsfe_pkg::CMD_START;
	logic [7:0]  header_byte    = '0;
	logic [31:0] payload_length = '0;
	logic [31:0] mask_key       = '0;
	logic [7:0]  data_byte      = '0;
	logic        out_valid;
	logic        out_ready      = 1'b0;
	logic [7:0]  out_byte;
	logic        end_of_run;
	logic        end_of_frame;

	// frame state as the encoder should hold it
	logic [31:0] frame_key  = '0;
	logic [1:0]  key_pos    = '0;
	logic [63:0] bytes_left = '0;
	logic        in_frame   = 1'b0;

	wire_beat_t  wire_q[$];     // beats still owed by the block, oldest first
	int          errors    = 0;
	int          send_idle = 0; // percent of cycles the sender holds back
	int          recv_idle = 0; // percent of cycles the receiver stalls

	// Directed rows. Header extremes, all three length encodings and their borders,
	// empty frame, stray payload bytes, abandoned frames and a key index that wraps.
	stim_row_t directed_rows [ROWS] = '{
		// payload byte right after reset: no frame open, dropped
		'{wsfe_pkg::CMD_DATA,  8'h00, 32'd0,        32'h0,        8'hA5, 1'b1, 5'd0,  8'h00, 1'b0},
		// empty frame: the last key byte closes it
		'{wsfe_pkg::CMD_START, 8'h81, 32'd0,        32'h11223344, 8'h00, 1'b1, 5'd6,  8'h44, 1'b1},
		'{wsfe_pkg::CMD_START, 8'h82, 32'd3,        32'hA1B2C3D4, 8'h00, 1'b1, 5'd6,  8'hD4, 1'b0},
		'{wsfe_pkg::CMD_DATA,  8'h00, 32'd0,        32'h0,        8'h00, 1'b1, 5'd1,  8'hA1, 1'b0},
		'{wsfe_pkg::CMD_DATA,  8'h00, 32'd0,        32'h0,        8'hFF, 1'b1, 5'd1,  8'h4D, 1'b0},
		'{wsfe_pkg::CMD_DATA,  8'h00, 32'd0,        32'h0,        8'h5A, 1'b1, 5'd1,  8'h99, 1'b1},
		// frame just closed: dropped again
		'{wsfe_pkg::CMD_DATA,  8'h00, 32'd0,        32'h0,        8'h3C, 1'b1, 5'd0,  8'h00, 1'b0},
		// largest length that fits the length byte
		'{wsfe_pkg::CMD_START, 8'hFF, 32'd125,      32'hFFFFFFFF, 8'h00, 1'b1, 5'd6,  8'hFF, 1'b0},
		'{wsfe_pkg::CMD_DATA,  8'h00, 32'd0,        32'h0,        8'hFF, 1'b1, 5'd1,  8'h00, 1'b0},
		// 16-bit length, abandons the open frame
		'{wsfe_pkg::CMD_START, 8'h00, 32'd126,      32'h0,        8'h00, 1'b1, 5'd8,  8'h00, 1'b0},
		'{wsfe_pkg::CMD_DATA,  8'h00, 32'd0,        32'h0,        8'h77, 1'b1, 5'd1,  8'h77, 1'b0},
		'{wsfe_pkg::CMD_START, 8'h8A, 32'd65535,    32'h0F0F0F0F, 8'h00, 1'b1, 5'd8,  8'h0F, 1'b0},
		// 64-bit length
		'{wsfe_pkg::CMD_START, 8'h09, 32'd65536,    32'hF0F0F0F0, 8'h00, 1'b1, 5'd14, 8'hF0, 1'b0},
		'{wsfe_pkg::CMD_START, 8'h70, 32'hFFFFFFFF, 32'h01020304, 8'h00, 1'b1, 5'd14, 8'h04, 1'b0},
		// five bytes: key index wraps past 3
		'{wsfe_pkg::CMD_DATA,  8'h00, 32'd0,        32'h0,        8'h10, 1'b0, 5'd0,  8'h00, 1'b0},
		'{wsfe_pkg::CMD_DATA,  8'h00, 32'd0,        32'h0,        8'h20, 1'b0, 5'd0,  8'h00, 1'b0},
		'{wsfe_pkg::CMD_DATA,  8'h00, 32'd0,        32'h0,        8'h30, 1'b0, 5'd0,  8'h00, 1'b0},
		'{wsfe_pkg::CMD_DATA,  8'h00, 32'd0,        32'h0,        8'h40, 1'b0, 5'd0,  8'h00, 1'b0},
		'{wsfe_pkg::CMD_DATA,  8'h00, 32'd0,        32'h0,        8'h50, 1'b0, 5'd0,  8'h00, 1'b0},
		// one-byte frame
		'{wsfe_pkg::CMD_START, 8'h89, 32'd1,        32'hDEADBEEF, 8'h00, 1'b1, 5'd6,  8'hEF, 1'b0},
		'{wsfe_pkg::CMD_DATA,  8'h00, 32'd0,        32'h0,        8'h00, 1'b1, 5'd1,  8'hDE, 1'b1},
		'{wsfe_pkg::CMD_START, 8'h8F, 32'd2,        32'h80000001, 8'h00, 1'b0, 5'd0,  8'h00, 1'b0},
		'{wsfe_pkg::CMD_DATA,  8'h00, 32'd0,        32'h0,        8'hFF, 1'b0, 5'd0,  8'h00, 1'b0},
		// start while one byte is still owed: old frame abandoned
		'{wsfe_pkg::CMD_START, 8'h88, 32'd0,        32'h0,        8'h00, 1'b1, 5'd6,  8'h00, 1'b1}
	};

	websocket_masked_frame_encoder_core u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command        (command),
		.header_byte    (header_byte),
		.payload_length (payload_length),
		.mask_key       (mask_key),
		.data_byte      (data_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_byte       (out_byte),
		.end_of_run     (end_of_run),
		.end_of_frame   (end_of_frame)
	);

	always #5 clk = ~clk;

	// key lane 0 is the top byte of the key
	function automatic logic [7:0] key_lane(input logic [31:0] key, input logic [1:0] lane);
		return key[8 * (3 - lane) +: 8];
	endfunction

	// Work out the beats that one accepted item owes, update the frame state,
	// and return how many beats were queued.
	function automatic int encode_beats(input logic cmd, input logic [7:0] hdr,
			input logic [31:0] len, input logic [31:0] key, input logic [7:0] data);
		logic [63:0] len_mask;
		logic [63:0] n;
		int          queued_before;
		len_mask      = (64'd1 << LEN_BITS) - 64'd1;
		n             = {32'd0, len} & len_mask;
		queued_before = wire_q.size();
		if (cmd == wsfe_pkg::CMD_START) begin
			wire_q.push_back(wire_beat_t'{hdr, 1'b0, 1'b0});
			// length byte, then the extended length big-endian where needed
			if (n <= wsfe_pkg::TINY_LIMIT) begin
				wire_q.push_back(wire_beat_t'{wsfe_pkg::MASK_FLAG | n[7:0], 1'b0, 1'b0});
			end else if (n <= wsfe_pkg::SHORT_LIMIT) begin
				wire_q.push_back(wire_beat_t'{wsfe_pkg::MASK_FLAG | wsfe_pkg::SHORT_CODE,
					1'b0, 1'b0});
				wire_q.push_back(wire_beat_t'{n[15:8], 1'b0, 1'b0});
				wire_q.push_back(wire_beat_t'{n[7:0], 1'b0, 1'b0});
			end else begin
				wire_q.push_back(wire_beat_t'{wsfe_pkg::MASK_FLAG | wsfe_pkg::LONG_CODE,
					1'b0, 1'b0});
				for (int i = wsfe_pkg::LONG_EXT - 1; i >= 0; i--) begin
					wire_q.push_back(wire_beat_t'{n[8 * i +: 8], 1'b0, 1'b0});
				end
			end
			// key bytes; the last one ends the run, and the frame too when empty
			for (int i = 0; i < wsfe_pkg::KEY_BYTES; i++) begin
				wire_q.push_back(wire_beat_t'{key_lane(key, 2'(i)),
					i == wsfe_pkg::KEY_BYTES - 1,
					(i == wsfe_pkg::KEY_BYTES - 1) && (n == 0)});
			end
			frame_key  = key;
			key_pos    = '0;
			bytes_left = n;
			in_frame   = (n != 0);
		end else if (in_frame) begin
			bytes_left = (bytes_left - 64'd1) & len_mask;
			wire_q.push_back(wire_beat_t'{data ^ key_lane(frame_key, key_pos), 1'b1,
				bytes_left == 0});
			key_pos = key_pos + 2'd1;
			if (bytes_left == 0) begin
				in_frame = 1'b0;
			end
		end
		// payload byte with no frame open: nothing owed, nothing changes
		return wire_q.size() - queued_before;
	endfunction

	// Present one item from the falling edge on, hold it until it is taken,
	// then queue the beats it owes.
	task automatic send_item(input logic cmd, input logic [7:0] hdr, input logic [31:0] len,
			input logic [31:0] key, input logic [7:0] data, output int n_beats);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid       <= 1'b1;
		command        <= cmd;
		header_byte    <= hdr;
		payload_length <= len;
		mask_key       <= key;
		data_byte      <= data;
		do @(posedge clk); while (!in_ready);
		n_beats = encode_beats(cmd, hdr, len, key, data);
	endtask

	// Random frames: mostly well-formed starts followed by their payload, some frames
	// cut short by the next start, and stray bytes while no frame is open.
	// Only items that the block acts on count toward n_items.
	task automatic random_frames(input int n_items);
		int          sent;
		int          n_data;
		int          pick;
		int          n_beats;
		logic [31:0] len;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(99);
			if (pick < 8 && !in_frame) begin
				// stray byte, random junk in the unused fields
				send_item(wsfe_pkg::CMD_DATA, 8'($urandom()), $urandom(), $urandom(),
					8'($urandom()), n_beats);
			end else begin
				pick = $urandom_range(99);
				if (pick < 65) begin
					len = $urandom_range(12);
				end else if (pick < 75) begin
					len = $urandom_range(125, 13);
				end else if (pick < 88) begin
					len = $urandom_range(65535, 126);
				end else if (pick < 95) begin
					len = $urandom_range(32'hFFFFFFFF, 65536);
				end else begin
					len = $urandom();
				end
				if (len <= 12) begin
					n_data = ($urandom_range(7) == 0) ? $urandom_range(int'(len)) : int'(len);
				end else if (len <= 140 && $urandom_range(9) == 0) begin
					n_data = int'(len);
				end else begin
					n_data = $urandom_range(8);
				end
				send_item(wsfe_pkg::CMD_START, 8'($urandom()), len, $urandom(),
					8'($urandom()), n_beats);
				sent++;
				for (int i = 0; i < n_data; i++) begin
					// unused start fields carry noise on payload beats
					send_item(wsfe_pkg::CMD_DATA, 8'($urandom()), $urandom(), $urandom(),
						8'($urandom()), n_beats);
					sent++;
				end
			end
		end
	endtask

	// receiver stalls at random, decided at the falling edge
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	// every beat taken is compared with the oldest one owed
	always @(posedge clk) begin : check_beats
		wire_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (wire_q.size() == 0) begin
				$display("%0t: beat with none owed: expected nothing, actual %h run %b frame %b",
					$time, out_byte, end_of_run, end_of_frame);
				errors++;
			end else begin
				want = wire_q.pop_front();
				if (out_byte !== want.value) begin
					$display("%0t: out_byte expected %h actual %h", $time, want.value, out_byte);
					errors++;
				end
				if (end_of_run !== want.run_end) begin
					$display("%0t: end_of_run expected %b actual %b", $time, want.run_end,
						end_of_run);
					errors++;
				end
				if (end_of_frame !== want.frame_end) begin
					$display("%0t: end_of_frame expected %b actual %b", $time, want.frame_end,
						end_of_frame);
					errors++;
				end
			end
		end
	end

	initial begin : stimulus
		int n_beats;
		// phase one: sender idles a little, receiver a lot
		send_idle = 17;
		recv_idle = 79;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < ROWS; r++) begin
			send_item(directed_rows[r].cmd, directed_rows[r].hdr, directed_rows[r].len,
				directed_rows[r].key, directed_rows[r].data, n_beats);
			if (directed_rows[r].typed) begin
				if (n_beats != int'(directed_rows[r].n_beats) || (n_beats > 0 &&
						(wire_q[$].value !== directed_rows[r].last_value ||
						wire_q[$].frame_end !== directed_rows[r].last_eof))) begin
					$display("%0t: row %0d expected %0d beats ending %h/%b, actual %0d beats",
						$time, r, directed_rows[r].n_beats, directed_rows[r].last_value,
						directed_rows[r].last_eof, n_beats);
					errors++;
				end
			end
		end

		random_frames(99);
		// phase two: roles swapped
		send_idle = 79;
		recv_idle = 17;
		random_frames(99);
		// phase three: full rate on both sides
		send_idle = 0;
		recv_idle = 0;
		random_frames(99);

		@(negedge clk);
		in_valid <= 1'b0;
		while (wire_q.size() != 0) @(posedge clk);
		// a dropped byte owes nothing; keep clocking after the queue drains so stray beats show
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// hang guard: far beyond the slowest correct run
	initial begin : watchdog
		#8000000;
		$display("%0t: timeout with %0d beats still owed", $time, wire_q.size());
		$display("Test completed with failures");
		$finish;
	end

endmodule
